>>> hw/rtl/rpi_pkg.sv
// Shared types and constants for the ray / plane intersection pipeline.
package rpi_pkg;

    localparam int RPI_FRAC_BITS = 16;
    localparam int RPI_QUO_W     = 31;
    localparam int RPI_DEN_W     = 64;
    localparam int RPI_NUM_W     = 65;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_px;
        logic signed [31:0] plane_py;
        logic signed [31:0] plane_pz;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_rpi_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
    } t_rpi_out;

endpackage

>>> hw/rtl/rpi_div.sv
// Pipelined restoring divider: one quotient bit per stage, flags quotients too wide for o_quo.
module rpi_div #(
    parameter int FRAC_BITS = rpi_pkg::RPI_FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [rpi_pkg::RPI_NUM_W-1:0] i_num,
    input  logic [rpi_pkg::RPI_DEN_W-1:0] i_den,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [rpi_pkg::RPI_QUO_W-1:0] o_quo,
    output logic                          o_sat,
    output logic [SIDE_W-1:0]             o_side
);
    import rpi_pkg::*;

    localparam int NW = RPI_NUM_W + FRAC_BITS;
    localparam int QW = RPI_QUO_W;
    localparam int DW = RPI_DEN_W;
    localparam int W  = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic          r_v    [0:QW];
    logic [W-1:0]  r_rem  [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic [QW-1:0] r_q    [0:QW];
    logic          r_sat  [0:QW];
    logic [SIDE_W-1:0] r_side [0:QW];

    logic [W-1:0]  n_rem0;
    logic          n_sat0;

    always_comb begin
        n_rem0 = W'(i_num) << FRAC_BITS;
        n_sat0 = n_rem0 >= (W'(i_den) << QW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= n_rem0;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_sat[0]  <= n_sat0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_stage
        logic [W-1:0]  n_trial;
        logic [W-1:0]  n_rem;
        logic [QW-1:0] n_q;

        always_comb begin
            n_trial = W'(r_den[k-1]) << (QW - k);
            n_rem   = r_rem[k-1];
            n_q     = r_q[k-1];
            if (r_rem[k-1] >= n_trial) begin
                n_rem         = r_rem[k-1] - n_trial;
                n_q[QW - k]   = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_den[k]  <= r_den[k-1];
                r_q[k]    <= n_q;
                r_sat[k]  <= r_sat[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_quo   = r_q[QW];
    assign o_sat   = r_sat[QW];
    assign o_side  = r_side[QW];

endmodule

>>> hw/rtl/ray_plane_intersection_top.sv
// Ray / plane intersection top level: dot products, divider and point pipeline.
// Fully pipelined ray / plane intersection: one word taken per clock unless held, one
// result per word. Dot-product stages feed the 31-stage bit-per-stage divider for t
// plus its saturation check stage, then the point stages. The whole pipe advances
// together; it holds while a result sits in the output register with i_stall high.
// No state survives between words, so reset only clears the valid bits.
module ray_plane_intersection_top #(
    parameter int FRAC_BITS = rpi_pkg::RPI_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rpi_pkg::t_rpi_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output rpi_pkg::t_rpi_out o_data
);
    import rpi_pkg::*;

    localparam int SIDE_W = 1 + 6 * 32;

    logic en;

    // stage 1: p - o
    logic               r_v1;
    logic signed [31:0] r1_n [0:2];
    logic signed [32:0] r1_df[0:2];
    logic signed [31:0] r1_o [0:2];
    logic signed [31:0] r1_d [0:2];

    // stage 2: products
    logic               r_v2;
    logic signed [63:0] r2_nd[0:2];
    logic signed [64:0] r2_np[0:2];
    logic signed [31:0] r2_o [0:2];
    logic signed [31:0] r2_d [0:2];

    // stage 3: sums
    logic               r_v3;
    logic signed [65:0] r3_vd;
    logic signed [66:0] r3_num;
    logic signed [31:0] r3_o [0:2];
    logic signed [31:0] r3_d [0:2];

    // stage 4: magnitudes and hit
    logic                 r_v4;
    logic [RPI_NUM_W-1:0] r4_an;
    logic [RPI_DEN_W-1:0] r4_ad;
    logic [SIDE_W-1:0]    r4_side;

    logic                 n_hit4;
    logic signed [65:0]   n_vdabs;
    logic signed [66:0]   n_numabs;

    logic                 dv_valid;
    logic [RPI_QUO_W-1:0] dv_quo;
    logic                 dv_sat;
    logic [SIDE_W-1:0]    dv_side;

    // stage M: d * t
    logic               r_vm;
    logic               rm_hit;
    logic signed [64:0] rm_prod[0:2];
    logic signed [31:0] rm_o   [0:2];

    // stage S: floor shift and saturate
    logic               r_vs;
    logic               rs_hit;
    logic signed [31:0] rs_ps[0:2];
    logic signed [31:0] rs_o [0:2];

    // output register
    logic      r_vout;
    t_rpi_out  r_out;

    logic [31:0]        n_t;
    logic signed [31:0] dv_o[0:2];
    logic signed [31:0] dv_d[0:2];
    logic signed [64:0] n_sh[0:2];
    logic signed [31:0] n_ps[0:2];
    logic signed [32:0] n_sum[0:2];
    logic signed [31:0] n_res[0:2];

    assign en      = !r_vout || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vout;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_n[0]  <= i_data.normal_x;
            r1_n[1]  <= i_data.normal_y;
            r1_n[2]  <= i_data.normal_z;
            r1_df[0] <= 33'(i_data.plane_px) - 33'(i_data.origin_x);
            r1_df[1] <= 33'(i_data.plane_py) - 33'(i_data.origin_y);
            r1_df[2] <= 33'(i_data.plane_pz) - 33'(i_data.origin_z);
            r1_o[0]  <= i_data.origin_x;
            r1_o[1]  <= i_data.origin_y;
            r1_o[2]  <= i_data.origin_z;
            r1_d[0]  <= i_data.dir_x;
            r1_d[1]  <= i_data.dir_y;
            r1_d[2]  <= i_data.dir_z;
            for (int i = 0; i < 3; i++) begin
                r2_nd[i] <= r1_n[i] * r1_d[i];
                r2_np[i] <= r1_n[i] * r1_df[i];
                r2_o[i]  <= r1_o[i];
                r2_d[i]  <= r1_d[i];
                r3_o[i]  <= r2_o[i];
                r3_d[i]  <= r2_d[i];
            end
            r3_vd  <= 66'(r2_nd[0]) + 66'(r2_nd[1]) + 66'(r2_nd[2]);
            r3_num <= 67'(r2_np[0]) + 67'(r2_np[1]) + 67'(r2_np[2]);
            r4_an   <= RPI_NUM_W'(n_numabs);
            r4_ad   <= RPI_DEN_W'(n_vdabs);
            r4_side <= {n_hit4, r3_o[0], r3_o[1], r3_o[2], r3_d[0], r3_d[1], r3_d[2]};
        end
    end

    always_comb begin
        n_hit4   = (r3_vd != '0) && ((r3_num == '0) || (r3_vd[65] == r3_num[66]));
        n_vdabs  = r3_vd[65] ? -r3_vd : r3_vd;
        n_numabs = r3_num[66] ? -r3_num : r3_num;
    end

    rpi_div #(
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v4),
        .i_num   (r4_an),
        .i_den   (r4_ad),
        .i_side  (r4_side),
        .o_valid (dv_valid),
        .o_quo   (dv_quo),
        .o_sat   (dv_sat),
        .o_side  (dv_side)
    );

    always_comb begin
        n_t = dv_sat ? 32'h7FFF_FFFF : {1'b0, dv_quo};
        for (int i = 0; i < 3; i++) begin
            dv_o[i] = dv_side[191 - 32*i -: 32];
            dv_d[i] = dv_side[95 - 32*i -: 32];
            n_sh[i] = rm_prod[i] >>> FRAC_BITS;
            if (n_sh[i][64:31] != {34{n_sh[i][31]}}) begin
                n_ps[i] = n_sh[i][64] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                n_ps[i] = n_sh[i][31:0];
            end
            n_sum[i] = 33'(rs_o[i]) + 33'(rs_ps[i]);
            if (n_sum[i][32] != n_sum[i][31]) begin
                n_res[i] = n_sum[i][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                n_res[i] = n_sum[i][31:0];
            end
            if (!rs_hit) begin
                n_res[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm   <= 1'b0;
            r_vs   <= 1'b0;
            r_vout <= 1'b0;
        end else if (en) begin
            r_vm   <= dv_valid;
            r_vs   <= r_vm;
            r_vout <= r_vs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_hit <= dv_side[SIDE_W-1];
            rs_hit <= rm_hit;
            for (int i = 0; i < 3; i++) begin
                rm_prod[i] <= dv_d[i] * $signed({1'b0, n_t});
                rm_o[i]    <= dv_o[i];
                rs_ps[i]   <= n_ps[i];
                rs_o[i]    <= rm_o[i];
            end
            r_out.hit   <= rs_hit;
            r_out.hit_x <= n_res[0];
            r_out.hit_y <= n_res[1];
            r_out.hit_z <= n_res[2];
        end
    end

endmodule

>>> bench/tb_ray_plane_intersection_top.sv
// Self-checking bench for the ray / plane intersection pipeline with a scoreboard.
`timescale 1ns / 100ps

module tb_ray_plane_intersection_top;
    import rpi_pkg::*;

    localparam int FB = RPI_FRAC_BITS;

    class intersect_board;
        t_rpi_out expected_hits[$];
        int       n_errors;

        function new();
            n_errors = 0;
        endfunction

        function automatic t_rpi_out predict_hit(t_rpi_in w);
            t_rpi_out          r;
            logic signed [127:0] vd, num, an, ad, q;
            logic signed [63:0]  t, prod, s;
            logic signed [63:0]  n[3], p[3], o[3], d[3];
            r = '0;
            n[0] = w.normal_x; n[1] = w.normal_y; n[2] = w.normal_z;
            p[0] = w.plane_px; p[1] = w.plane_py; p[2] = w.plane_pz;
            o[0] = w.origin_x; o[1] = w.origin_y; o[2] = w.origin_z;
            d[0] = w.dir_x;    d[1] = w.dir_y;    d[2] = w.dir_z;
            vd = 0;
            num = 0;
            for (int i = 0; i < 3; i++) begin
                vd  = vd + 128'(signed'(n[i] * d[i]));
                num = num + 128'(signed'(n[i] * (p[i] - o[i])));
            end
            if (vd == 0) return r;
            if (num != 0 && (num < 0) != (vd < 0)) return r;
            an = (num < 0) ? -num : num;
            ad = (vd < 0) ? -vd : vd;
            q = (an <<< FB) / ad;
            t = (q > 128'sh7FFFFFFF) ? 64'sh7FFFFFFF : 64'(q);
            r.hit = 1'b1;
            for (int i = 0; i < 3; i++) begin
                prod = (d[i] * t) >>> FB;
                if (prod > 64'sh7FFFFFFF) prod = 64'sh7FFFFFFF;
                if (prod < -64'sh80000000) prod = -64'sh80000000;
                s = o[i] + prod;
                if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
                if (s < -64'sh80000000) s = -64'sh80000000;
                case (i)
                    0: r.hit_x = s[31:0];
                    1: r.hit_y = s[31:0];
                    default: r.hit_z = s[31:0];
                endcase
            end
            return r;
        endfunction

        function void note_ray(t_rpi_in w);
            expected_hits.push_back(predict_hit(w));
        endfunction

        function void check_hit(t_rpi_out got);
            t_rpi_out e;
            if (expected_hits.size() == 0) begin
                $error("result word with nothing expected");
                n_errors++;
                return;
            end
            e = expected_hits.pop_front();
            if (got.hit !== e.hit) begin
                $error("hit exp %0d got %0d", e.hit, got.hit); n_errors++;
            end
            if (got.hit_x !== e.hit_x) begin
                $error("hit_x exp %0d got %0d", e.hit_x, got.hit_x); n_errors++;
            end
            if (got.hit_y !== e.hit_y) begin
                $error("hit_y exp %0d got %0d", e.hit_y, got.hit_y); n_errors++;
            end
            if (got.hit_z !== e.hit_z) begin
                $error("hit_z exp %0d got %0d", e.hit_z, got.hit_z); n_errors++;
            end
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_rpi_in  i_data;
    logic     o_valid;
    logic     i_stall;
    t_rpi_out o_data;

    intersect_board board;
    int send_idle_pct;
    int recv_stall_pct;

    ray_plane_intersection_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) board.check_hit(o_data);
            if (i_valid && !o_stall) board.note_ray(i_data);
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic [31:0] pick_val();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            3: return 32'($signed($urandom_range(0, 512)) - 256);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_rpi_in random_ray();
        t_rpi_in w;
        w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(3) != 0) begin
            w.normal_x = pick_val(); w.normal_y = pick_val(); w.normal_z = pick_val();
            w.plane_px = pick_val(); w.plane_py = pick_val(); w.plane_pz = pick_val();
            w.origin_x = pick_val(); w.origin_y = pick_val(); w.origin_z = pick_val();
            w.dir_x = pick_val(); w.dir_y = pick_val(); w.dir_z = pick_val();
        end
        if ($urandom_range(7) == 0) w.dir_z = '0;
        return w;
    endfunction

    task automatic send_ray(t_rpi_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_hits.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_rpi_in make_ray(int nx, int ny, int nz, int px, int py, int pz,
                                         int ox, int oy, int oz, int dx, int dy, int dz);
        return '{nx, ny, nz, px, py, pz, ox, oy, oz, dx, dy, dz};
    endfunction

    initial begin
        t_rpi_in w;
        int one;
        board = new();
        one = 1 << FB;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // simple hit, parallel, behind, origin on plane, large t, saturation
        send_ray(make_ray(0, 0, one, 0, 0, 5 * one, 0, 0, 0, 0, 0, one));
        send_ray(make_ray(0, 0, one, 0, 0, 5 * one, 0, 0, 0, one, 0, 0));
        send_ray(make_ray(0, 0, one, 0, 0, -5 * one, 0, 0, 0, 0, 0, one));
        send_ray(make_ray(0, one, 0, 0, 3 * one, 0, one, 3 * one, 2, one, -one, 0));
        send_ray(make_ray(0, 0, one, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h80000000, one, -one, 1));
        send_ray(make_ray(0, 0, 1, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFF0, 0, 0,
                          32'h7FFFFFFF, 32'h80000000, 1));
        send_ray(make_ray(32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000));
        send_ray(make_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h80000000, 32'h80000000, 32'h80000000,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                          32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_ray('1);
        send_ray('0);
        send_ray(make_ray(one, one, one, 0, 0, 0, -one, -one, -one, -1, -1, -1));
        send_ray(make_ray(-one, 0, 0, -7 * one, 0, 0, 0, 9, -9, -one / 2, 3, 7));
        go_quiet();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (int k = 0; k < 125; k++) begin
                w = random_ray();
                send_ray(w);
                if (k == 60) go_quiet();
            end
            go_quiet();
        end
        recv_stall_pct = 0;
        repeat (60) @(posedge i_clk);

        if (board.n_errors == 0 && board.expected_hits.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
